// File: hw/rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg - shared types and constants for the frustum box cull test
// Plane register layout, plane index codes and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

    // Six planes, three axes each
    localparam int PLANE_COUNT = 6;
    localparam int AXIS_COUNT  = 3;

    // Normal Q2.14, distance Q8.8
    localparam int NORMAL_W    = 16;
    localparam int DIST_W      = 16;
    localparam int NORMAL_FRAC = 14;

    // Configuration register index
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        PLANE_NEAR   = 3'd0,
        PLANE_FAR    = 3'd1,
        PLANE_LEFT   = 3'd2,
        PLANE_RIGHT  = 3'd3,
        PLANE_TOP    = 3'd4,
        PLANE_BOTTOM = 3'd5
    } plane_idx_t;

    // Packed register: distance in the top half-word, nx in the bottom
    typedef struct packed {
        logic signed [DIST_W-1:0]   distance;
        logic signed [NORMAL_W-1:0] nz;
        logic signed [NORMAL_W-1:0] ny;
        logic signed [NORMAL_W-1:0] nx;
    } plane_t;

endpackage

`default_nettype wire

// File: hw/rtl/frustum_box_cull_test.sv
// ----------------------------------------------------------------------------
// frustum_box_cull_test - six-plane view-frustum test of an axis-aligned box
// Tests each box request against six configured planes, one box per cycle.
// ----------------------------------------------------------------------------
// Takes one box request per clock and returns inside_res from the last stage's
// register (1 = not wholly outside any plane). The pipeline is three
// register stages: 36 parallel coordinate-by-normal multipliers, a per-axis
// pick of the better corner, then the three-term sum, compare against the
// scaled distance and the AND over planes, which is also the output register.
// Each stage holds under back-pressure and fills bubbles, so throughput is one
// request per cycle whenever m_ready is high. Planes are written through the
// cfg port (index 0..5: near, far, left, right, top, bottom; others ignored)
// and must only change while no request is in flight. All planes reset to
// zero, which reports every box as inside.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_box_cull_test #(
    parameter int COORD_WIDTH = 16
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,

    // Configuration write channel
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [fbc_pkg::CFG_DATA_W-1:0]   cfg_data,

    // Box request channel
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire logic signed [COORD_WIDTH-1:0]    s_min_x,
    input  wire logic signed [COORD_WIDTH-1:0]    s_min_y,
    input  wire logic signed [COORD_WIDTH-1:0]    s_min_z,
    input  wire logic signed [COORD_WIDTH-1:0]    s_max_x,
    input  wire logic signed [COORD_WIDTH-1:0]    s_max_y,
    input  wire logic signed [COORD_WIDTH-1:0]    s_max_z,

    // Result channel
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic                                  m_inside_res
);
    import fbc_pkg::*;

    localparam int PROD_W = COORD_WIDTH + NORMAL_W;

    plane_t                   planes_reg [PLANE_COUNT];
    logic signed [COORD_WIDTH-1:0] lo    [AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] hi    [AXIS_COUNT];
    logic signed [PROD_W-1:0] lo_prod    [PLANE_COUNT][AXIS_COUNT];
    logic signed [PROD_W-1:0] hi_prod    [PLANE_COUNT][AXIS_COUNT];
    logic signed [PROD_W-1:0] max_val    [PLANE_COUNT][AXIS_COUNT];

    logic v1_reg, v2_reg, v3_reg;
    logic rdy2, rdy3;
    logic en1, en2, en3;
    logic inside_reg;

    // Plane registers, to be written only while idle; the block itself does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                planes_reg[p] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index <= CFG_INDEX_W'(PLANE_BOTTOM)) begin
                planes_reg[cfg_index] <= plane_t'(cfg_data);
            end
        end
    end

    // Stage handshake: a stage loads when empty or when its contents move on
    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign s_ready = !v1_reg || rdy2;

    assign en1 = s_valid && s_ready;
    assign en2 = v1_reg && rdy2;
    assign en3 = v2_reg && rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (s_ready) v1_reg <= s_valid;
            if (rdy2)    v2_reg <= v1_reg;
            if (rdy3)    v3_reg <= v2_reg;
        end
    end

    // Corner coordinates
    assign lo[0] = s_min_x;
    assign lo[1] = s_min_y;
    assign lo[2] = s_min_z;
    assign hi[0] = s_max_x;
    assign hi[1] = s_max_y;
    assign hi[2] = s_max_z;

    fbc_prod_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prod (
        .aclk        (aclk),
        .en          (en1),
        .planes      (planes_reg),
        .lo          (lo),
        .hi          (hi),
        .lo_prod_reg (lo_prod),
        .hi_prod_reg (hi_prod)
    );

    fbc_max_stage #(
        .PROD_W  (PROD_W)
    ) u_max (
        .aclk    (aclk),
        .en      (en2),
        .lo_prod (lo_prod),
        .hi_prod (hi_prod),
        .max_reg (max_val)
    );

    fbc_eval_stage #(
        .PROD_W     (PROD_W)
    ) u_eval (
        .aclk       (aclk),
        .en         (en3),
        .planes     (planes_reg),
        .max_val    (max_val),
        .inside_reg (inside_reg)
    );

    assign m_valid      = v3_reg;
    assign m_inside_res = inside_reg;

endmodule

`default_nettype wire

// File: hw/rtl/fbc_prod_stage.sv
// ----------------------------------------------------------------------------
// fbc_prod_stage - first pipeline stage: coordinate by normal products
// Forms min*n and max*n for every plane and axis and registers them.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_prod_stage #(
    parameter int COORD_WIDTH = 16
) (
    input  wire                                   aclk,
    input  wire                                   en,
    input  wire fbc_pkg::plane_t                  planes [fbc_pkg::PLANE_COUNT],
    input  wire logic signed [COORD_WIDTH-1:0]    lo     [fbc_pkg::AXIS_COUNT],
    input  wire logic signed [COORD_WIDTH-1:0]    hi     [fbc_pkg::AXIS_COUNT],
    output logic signed [COORD_WIDTH+fbc_pkg::NORMAL_W-1:0]
                                                  lo_prod_reg
                                                  [fbc_pkg::PLANE_COUNT][fbc_pkg::AXIS_COUNT],
    output logic signed [COORD_WIDTH+fbc_pkg::NORMAL_W-1:0]
                                                  hi_prod_reg
                                                  [fbc_pkg::PLANE_COUNT][fbc_pkg::AXIS_COUNT]
);
    import fbc_pkg::*;

    localparam int PROD_W = COORD_WIDTH + NORMAL_W;

    logic signed [PROD_W-1:0]   lo_prod_next [PLANE_COUNT][AXIS_COUNT];
    logic signed [PROD_W-1:0]   hi_prod_next [PLANE_COUNT][AXIS_COUNT];
    logic signed [NORMAL_W-1:0] nrm          [PLANE_COUNT][AXIS_COUNT];

    // Unpack normals per axis
    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            nrm[p][0] = planes[p].nx;
            nrm[p][1] = planes[p].ny;
            nrm[p][2] = planes[p].nz;
        end
    end

    // Exact signed products, one multiplier each
    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
                lo_prod_next[p][a] = PROD_W'(lo[a]) * PROD_W'(nrm[p][a]);
                hi_prod_next[p][a] = PROD_W'(hi[a]) * PROD_W'(nrm[p][a]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fbc_max_stage.sv
// ----------------------------------------------------------------------------
// fbc_max_stage - second pipeline stage: best corner per axis
// The dot product is separable, so the best of eight corners is the sum of
// the larger product on each axis. This stage picks those per axis.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_max_stage #(
    parameter int PROD_W = 32
) (
    input  wire                       aclk,
    input  wire                       en,
    input  wire logic signed [PROD_W-1:0]
                                      lo_prod [fbc_pkg::PLANE_COUNT][fbc_pkg::AXIS_COUNT],
    input  wire logic signed [PROD_W-1:0]
                                      hi_prod [fbc_pkg::PLANE_COUNT][fbc_pkg::AXIS_COUNT],
    output logic signed [PROD_W-1:0]
                                      max_reg [fbc_pkg::PLANE_COUNT][fbc_pkg::AXIS_COUNT]
);
    import fbc_pkg::*;

    logic signed [PROD_W-1:0] max_next [PLANE_COUNT][AXIS_COUNT];

    // Larger of the two corner products
    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
                max_next[p][a] = (hi_prod[p][a] > lo_prod[p][a]) ? hi_prod[p][a]
                                                                  : lo_prod[p][a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            max_reg <= max_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fbc_eval_stage.sv
// ----------------------------------------------------------------------------
// fbc_eval_stage - final pipeline stage: plane compare and verdict
// Sums the per-axis maxima, compares against the scaled distance and
// registers the AND of all six plane tests.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_eval_stage #(
    parameter int PROD_W = 32
) (
    input  wire                       aclk,
    input  wire                       en,
    input  wire fbc_pkg::plane_t      planes  [fbc_pkg::PLANE_COUNT],
    input  wire logic signed [PROD_W-1:0]
                                      max_val [fbc_pkg::PLANE_COUNT][fbc_pkg::AXIS_COUNT],
    output logic                      inside_reg
);
    import fbc_pkg::*;

    // Wide enough for a three-term sum and for distance * 2^14
    localparam int SUM_RAW_W = PROD_W + 2;
    localparam int THR_RAW_W = DIST_W + NORMAL_FRAC;
    localparam int CMP_W     = ((SUM_RAW_W > THR_RAW_W) ? SUM_RAW_W : THR_RAW_W) + 1;

    logic signed [CMP_W-1:0] dot_sum [PLANE_COUNT];
    logic signed [CMP_W-1:0] thr     [PLANE_COUNT];
    logic [PLANE_COUNT-1:0]  pass;
    logic                    inside_next;

    // Best corner against plane distance
    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            dot_sum[p] = CMP_W'(max_val[p][0]) + CMP_W'(max_val[p][1])
                       + CMP_W'(max_val[p][2]);
            thr[p]     = CMP_W'(planes[p].distance) <<< NORMAL_FRAC;
            pass[p]    = (dot_sum[p] >= thr[p]);
        end
        inside_next = &pass;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inside_reg <= inside_next;
        end
    end

endmodule

`default_nettype wire

// File: dv/frustum_box_cull_test_tb.sv
// ----------------------------------------------------------------------------
// frustum_box_cull_test_tb - box-against-frustum cull checker
// Loads plane sets through the cfg port, streams box requests with random
// gaps and back-pressure, and compares every inside_res against a
// fixed-point plane test kept in step with the loaded planes.
// ----------------------------------------------------------------------------
module frustum_box_cull_test_tb;

    import fbc_pkg::*;

    localparam int COORD_W          = 16;
    localparam int LATENCY          = 3;
    localparam int ONE_Q8           = 256;      // 1.0 in Q8.8
    localparam int UNIT_N           = 16384;    // 1.0 in Q2.14
    localparam int RANDOM_PHASES    = 8;
    localparam int BOXES_PER_PHASE  = 75;
    localparam int HOLD_AFTER       = 110;
    localparam int HOLD_CYCLES      = 300;
    localparam int CYCLE_LIMIT      = 400000;

    // Indexes past the last plane; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
    } box_t;

    typedef struct {
        int seq;
        bit in_view;
    } verdict_t;

    logic                        aclk         = 1'b0;
    logic                        aresetn      = 1'b0;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_W-1:0]      cfg_index    = '0;
    logic [CFG_DATA_W-1:0]       cfg_data     = '0;
    logic                        s_valid      = 1'b0;
    logic                        s_ready;
    logic signed [COORD_W-1:0]   s_min_x      = '0;
    logic signed [COORD_W-1:0]   s_min_y      = '0;
    logic signed [COORD_W-1:0]   s_min_z      = '0;
    logic signed [COORD_W-1:0]   s_max_x      = '0;
    logic signed [COORD_W-1:0]   s_max_y      = '0;
    logic signed [COORD_W-1:0]   s_max_z      = '0;
    logic                        m_valid;
    logic                        m_ready      = 1'b0;
    logic                        m_inside_res;

    // Testbench copy of the plane registers
    plane_t   frustum_planes[PLANE_COUNT] = '{default: '0};
    box_t     boxes_pending[$];
    verdict_t verdicts_due[$];
    int       boxes_accepted = 0;
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       src_gap        = 0;
    int       sink_pause     = 0;
    bit       gaps_on        = 1'b1;
    logic     sink_hold      = 1'b0;

    frustum_box_cull_test #(
        .COORD_WIDTH (COORD_W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_min_x      (s_min_x),
        .s_min_y      (s_min_y),
        .s_min_z      (s_min_z),
        .s_max_x      (s_max_x),
        .s_max_y      (s_max_y),
        .s_max_z      (s_max_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_inside_res (m_inside_res)
    );

    always #5 aclk = ~aclk;

    // Exact plane test: a plane passes if any corner is on or in front of it
    function automatic bit box_in_frustum(box_t b);
        longint lo[3], hi[3];
        longint x, y, z, dot, bound;
        bit     any_pass;
        bit     in_view;
        lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
        hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
        in_view = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            any_pass = 1'b0;
            bound = longint'(frustum_planes[p].distance) * (longint'(1) << NORMAL_FRAC);
            for (int c = 0; c < 8; c++) begin
                x = ((c & 4) != 0) ? hi[0] : lo[0];
                y = ((c & 2) != 0) ? hi[1] : lo[1];
                z = ((c & 1) != 0) ? hi[2] : lo[2];
                dot = x * longint'(frustum_planes[p].nx)
                    + y * longint'(frustum_planes[p].ny)
                    + z * longint'(frustum_planes[p].nz);
                if (dot - bound >= 0)
                    any_pass = 1'b1;
            end
            if (!any_pass)
                in_view = 1'b0;
        end
        return in_view;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[COORD_W-1:0];
    endfunction

    function automatic box_t mk_box(int x0, int y0, int z0, int x1, int y1, int z1);
        box_t b;
        b.min_x = clamp_coord(x0); b.min_y = clamp_coord(y0); b.min_z = clamp_coord(z0);
        b.max_x = clamp_coord(x1); b.max_y = clamp_coord(y1); b.max_z = clamp_coord(z1);
        return b;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] make_plane(int nx, int ny, int nz, int d);
        plane_t p;
        p.nx       = nx[NORMAL_W-1:0];
        p.ny       = ny[NORMAL_W-1:0];
        p.nz       = nz[NORMAL_W-1:0];
        p.distance = d[DIST_W-1:0];
        return p;
    endfunction

    function automatic int jitter(int span);
        if (span <= 0)
            return 0;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 93)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // Mostly well-formed boxes around the frustum, some points, swaps and noise
    function automatic box_t random_box(int spread);
        int r;
        int ctr[3], ext[3], lo[3], hi[3];
        r = $urandom_range(0, 99);
        if (r < 10)
            return box_t'({$urandom(), $urandom(), $urandom()});
        for (int a = 0; a < 3; a++) begin
            ctr[a] = jitter(2 * spread);
            ext[a] = (r < 25) ? 0 : int'($urandom_range(0, spread));
            lo[a]  = ctr[a] - ext[a];
            hi[a]  = ctr[a] + ext[a];
        end
        if (r >= 25 && r < 32)
            return mk_box(hi[0], hi[1], hi[2], lo[0], lo[1], lo[2]);
        return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] ERROR %s", $realtime, msg);
        mismatch_count++;
    endtask

    // One register write; the local copy follows only for mapped indexes
    task automatic write_plane(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0]  value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < PLANE_COUNT)
            frustum_planes[idx] = value;
    endtask

    // Six axis-aligned planes of a cube of the given half size, slightly tilted
    task automatic load_frustum(int half, int tilt);
        int axis_of[PLANE_COUNT] = '{2, 2, 0, 0, 1, 1};
        int sign_of[PLANE_COUNT] = '{1, -1, 1, -1, -1, 1};
        int n[3];
        for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int a = 0; a < 3; a++)
                n[a] = jitter(tilt);
            n[axis_of[p]] += sign_of[p] * UNIT_N;
            write_plane(CFG_INDEX_W'(p), make_plane(n[0], n[1], n[2], -half + jitter(half / 8)));
        end
    endtask

    // Wait for every request to be answered, then let the pipe empty
    task automatic drain();
        while (boxes_pending.size() != 0 || verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    // Box request driver
    always @(posedge aclk) begin : box_driver
        bit       fire;
        bit       offer;
        verdict_t v;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            fire  = s_valid && s_ready;
            offer = 1'b0;
            if (fire) begin
                v.seq     = boxes_accepted;
                v.in_view = box_in_frustum(boxes_pending[0]);
                verdicts_due.push_back(v);
                void'(boxes_pending.pop_front());
                boxes_accepted++;
            end
            if (s_valid && !fire) begin
                offer = 1'b1;
            end else if (src_gap > 0) begin
                src_gap--;
            end else if (boxes_pending.size() != 0) begin
                offer   = 1'b1;
                s_min_x <= boxes_pending[0].min_x;
                s_min_y <= boxes_pending[0].min_y;
                s_min_z <= boxes_pending[0].min_z;
                s_max_x <= boxes_pending[0].max_x;
                s_max_y <= boxes_pending[0].max_y;
                s_max_z <= boxes_pending[0].max_z;
                if (gaps_on && $urandom_range(0, 3) == 0)
                    src_gap = idle_len();
            end
            s_valid <= offer;
        end
    end

    // Result monitor and receiver stalls
    always @(posedge aclk) begin : result_monitor
        verdict_t v;
        bit       next_ready;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_pause = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    flag_mismatch($sformatf("unrequested result inside_res=%0b", m_inside_res));
                end else begin
                    v = verdicts_due.pop_front();
                    if (m_inside_res !== v.in_view)
                        flag_mismatch($sformatf("box %0d: inside_res=%b, want %0b",
                                                v.seq, m_inside_res, v.in_view));
                end
            end
            next_ready = 1'b0;
            if (sink_hold) begin
                next_ready = 1'b0;
            end else if (sink_pause > 0) begin
                sink_pause--;
            end else begin
                next_ready = 1'b1;
                if (gaps_on && $urandom_range(0, 4) == 0)
                    sink_pause = idle_len();
            end
            m_ready <= next_ready;
        end
    end

    // Long receiver hold-off so the pipe fills and s_ready drops
    initial begin : long_hold
        while (boxes_accepted < HOLD_AFTER)
            @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("frustum_box_cull_test: mismatch");
            $finish;
        end
    end

    // Phases: directed plane sets first, then random ones
    initial begin : stimulus
        int sel;
        int half;
        int spread;
        int h;
        logic [CFG_DATA_W-1:0] corner_vals[4];
        corner_vals = '{64'h0, 64'hffff_ffff_ffff_ffff,
                        64'h7fff_7fff_7fff_7fff, 64'h8000_8000_8000_8000};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Planes at reset: everything is inside
        boxes_pending.push_back(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        boxes_pending.push_back(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        boxes_pending.push_back(mk_box(32767, 0, -32768, -32768, 0, 32767));
        boxes_pending.push_back(mk_box(0, 0, 0, 0, 0, 0));
        drain();

        // Unit cube of half size ten
        h = 10 * ONE_Q8;
        write_plane(PLANE_NEAR,   make_plane(0, 0, UNIT_N, -h));
        write_plane(PLANE_FAR,    make_plane(0, 0, -UNIT_N, -h));
        write_plane(PLANE_LEFT,   make_plane(UNIT_N, 0, 0, -h));
        write_plane(PLANE_RIGHT,  make_plane(-UNIT_N, 0, 0, -h));
        write_plane(PLANE_TOP,    make_plane(0, -UNIT_N, 0, -h));
        write_plane(PLANE_BOTTOM, make_plane(0, UNIT_N, 0, -h));
        boxes_pending.push_back(mk_box(0, 0, 0, 0, 0, 0));
        boxes_pending.push_back(mk_box(2 * h, 0, 0, 2 * h, 0, 0));
        boxes_pending.push_back(mk_box(h / 2, 0, 0, h + h / 2, 0, 0));
        boxes_pending.push_back(mk_box(h + ONE_Q8, 0, 0, h + 2 * ONE_Q8, 0, 0));
        // min above max, straddling the right plane
        boxes_pending.push_back(mk_box(h + h / 2, 0, 0, h / 2, 0, 0));
        boxes_pending.push_back(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        // exactly on the plane, then one step past it
        boxes_pending.push_back(mk_box(h, 0, 0, h, 0, 0));
        boxes_pending.push_back(mk_box(h + 1, 0, 0, h + 1, 0, 0));
        drain();

        // Zero normal with positive distance rejects every box
        write_plane(PLANE_NEAR, make_plane(0, 0, 0, 1));
        boxes_pending.push_back(mk_box(0, 0, 0, 0, 0, 0));
        boxes_pending.push_back(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        drain();
        // Zero normal with zero or negative distance always passes
        write_plane(PLANE_NEAR, make_plane(0, 0, 0, 0));
        boxes_pending.push_back(mk_box(0, 0, 0, 0, 0, 0));
        drain();
        write_plane(PLANE_NEAR, make_plane(0, 0, 0, -32768));
        write_plane(IDX_UNMAPPED_LO, 64'hffff_ffff_ffff_ffff);
        write_plane(IDX_UNMAPPED_HI, 64'h0000_0000_0000_0001);
        boxes_pending.push_back(mk_box(ONE_Q8, -ONE_Q8, 0, ONE_Q8, -ONE_Q8, 0));
        drain();

        // Extreme register contents
        write_plane(PLANE_NEAR,   make_plane(-32768, 32767, -32768, 32767));
        write_plane(PLANE_FAR,    corner_vals[3]);
        write_plane(PLANE_LEFT,   corner_vals[1]);
        write_plane(PLANE_RIGHT,  corner_vals[2]);
        write_plane(PLANE_TOP,    corner_vals[0]);
        write_plane(PLANE_BOTTOM, corner_vals[0]);
        boxes_pending.push_back(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        boxes_pending.push_back(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        boxes_pending.push_back(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        drain();

        // Random plane sets, each with a stream of boxes
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            gaps_on = (ph % 3 != 1);
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                half = $urandom_range(2, 60) * ONE_Q8;
                load_frustum(half, $urandom_range(0, 4000));
                spread = half;
            end else if (sel < 8) begin
                for (int p = 0; p < PLANE_COUNT; p++)
                    write_plane(CFG_INDEX_W'(p), {$urandom(), $urandom()});
                spread = 16000;
            end else begin
                for (int p = 0; p < PLANE_COUNT; p++)
                    write_plane(CFG_INDEX_W'(p), corner_vals[$urandom_range(0, 3)]);
                spread = 8000;
            end
            for (int i = 0; i < BOXES_PER_PHASE; i++)
                boxes_pending.push_back(random_box(spread));
            drain();
        end

        repeat (LATENCY + 5) @(posedge aclk);
        if (verdicts_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", verdicts_due.size()));
        if (mismatch_count == 0)
            $display("frustum_box_cull_test: match");
        else
            $display("frustum_box_cull_test: mismatch");
        $finish;
    end

endmodule
